// ----- design/utf8_code_point_encoder_macros.svh -----
// Assertion macros used by the encoder checker.
`ifndef UTF8_CODE_POINT_ENCODER_MACROS_SVH
`define UTF8_CODE_POINT_ENCODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UTF8ENC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define UTF8ENC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- design/utf8enc_pkg.sv -----
// Types, constants and the encoding function of the UTF-8 code point encoder.
package utf8enc_pkg;

	localparam int CP_W        = 32;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 3;
	localparam int MAX_BYTES   = 4;
	localparam int IDX_W       = $clog2(MAX_BYTES);
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - LEN_W;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [LEN_W-1:0]  len_t;

	localparam len_t LEN_0 = 3'd0;
	localparam len_t LEN_1 = 3'd1;
	localparam len_t LEN_2 = 3'd2;
	localparam len_t LEN_3 = 3'd3;
	localparam len_t LEN_4 = 3'd4;
	localparam len_t LEN_5 = 3'd5;
	localparam len_t LEN_6 = 3'd6;

	localparam byte_t LEAD_2B = 8'hC0;
	localparam byte_t LEAD_3B = 8'hE0;
	localparam byte_t LEAD_4B = 8'hF0;
	localparam byte_t CONT_B  = 8'h80;

	localparam cp_t MAX_1B      = 32'h0000_007F;
	localparam cp_t MAX_2B      = 32'h0000_07FF;
	localparam cp_t MAX_3B      = 32'h0000_FFFF;
	localparam cp_t MAX_4B      = 32'h001F_FFFF;
	localparam cp_t MAX_5B      = 32'h03FF_FFFF;
	localparam cp_t MAX_6B      = 32'h7FFF_FFFF;
	localparam cp_t MAX_SCALAR  = 32'h0010_FFFF;
	localparam cp_t NONCHAR_LO  = 32'h0000_FFFE;
	localparam cp_t NONCHAR_HI  = 32'h0000_FFFF;

	typedef struct packed {
		byte_t [MAX_BYTES-1:0] bytes;
		logic [IDX_W-1:0]      last_idx;
		logic                  invalid;
		len_t                  len;
	} enc_t;

	function automatic len_t length_of(input cp_t cp);
		len_t len;
		if (cp <= MAX_1B) begin
			len = LEN_1;
		end else if (cp <= MAX_2B) begin
			len = LEN_2;
		end else if (cp <= MAX_3B) begin
			len = LEN_3;
		end else if (cp <= MAX_4B) begin
			len = LEN_4;
		end else if (cp <= MAX_5B) begin
			len = LEN_5;
		end else if (cp <= MAX_6B) begin
			len = LEN_6;
		end else begin
			len = LEN_0;
		end
		return len;
	endfunction

	function automatic enc_t encode(input cp_t cp);
		enc_t e;
		len_t len;
		len = length_of(cp);
		e = '0;
		e.len = len;
		if ((len inside {LEN_0, LEN_5, LEN_6}) || (cp inside {NONCHAR_LO, NONCHAR_HI})
				|| (cp > MAX_SCALAR)) begin
			e.invalid = 1'b1;
		end else begin
			case (len)
				LEN_1: begin
					e.bytes[0] = {1'b0, cp[6:0]};
				end
				LEN_2: begin
					e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
					e.bytes[1] = CONT_B | {2'b00, cp[5:0]};
					e.last_idx = IDX_W'(1);
				end
				LEN_3: begin
					e.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
					e.bytes[1] = CONT_B | {2'b00, cp[11:6]};
					e.bytes[2] = CONT_B | {2'b00, cp[5:0]};
					e.last_idx = IDX_W'(2);
				end
				LEN_4: begin
					e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
					e.bytes[1] = CONT_B | {2'b00, cp[17:12]};
					e.bytes[2] = CONT_B | {2'b00, cp[11:6]};
					e.bytes[3] = CONT_B | {2'b00, cp[5:0]};
					e.last_idx = IDX_W'(3);
				end
				default: begin
					e.invalid = 1'b1;
				end
			endcase
		end
		return e;
	endfunction

endpackage

// ----- design/utf8_code_point_encoder.sv -----
// Top level of the UTF-8 code point encoder: input register, byte sequencer, result register.
//
// One 32-bit code point enters per beat on the s_axis channel. Each valid point
// leaves as 1 to 4 beats on the m_axis channel, lead byte first, tlast on the
// final byte. A rejected point (noncharacter, beyond 0x10FFFF, 5/6-byte form or
// above 0x7FFFFFFF) leaves as one beat with tuser set, byte zero and tlast set.
// m_axis_tdata carries the byte and the range length on every beat.
// The code point passes the input register and then the result register; the
// first byte is valid on m_axis once the result register has loaded it.
// Throughput: one output beat per cycle while m_axis_tready is high; a point
// holds the input register until its last byte is loaded into the result
// register, so single-byte points stream at one per cycle. The result
// register drains while the next point is already accepted.
// Reset clears the input and result valid flags; nothing carries across points.
// When the receiver stalls, the result register holds its beat and the input
// register holds the pending point, so s_axis_tready drops after one point.
module utf8_code_point_encoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [utf8enc_pkg::CP_W-1:0]        s_axis_tdata,  // [31:0] code_point
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [utf8enc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [10:8] byte_count
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser   // [0] invalid
);
	import utf8enc_pkg::*;

	logic             valid_s1;
	cp_t              cp_s1;
	logic [IDX_W-1:0] idx_s1;
	enc_t             enc;
	logic             sel_last;
	logic             out_load;
	logic             in_fire;
	logic             tvalid_q;
	byte_t            byte_q;
	len_t             cnt_q;
	logic             last_q;
	logic             inv_q;

	assign enc           = encode(cp_s1);
	assign sel_last      = (idx_s1 == enc.last_idx);
	assign out_load      = valid_s1 && (!tvalid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || (out_load && sel_last);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			if (out_load) begin
				idx_s1 <= idx_s1 + IDX_W'(1);
				if (sel_last) begin
					valid_s1 <= 1'b0;
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
				idx_s1   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cp_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			byte_q <= enc.bytes[idx_s1];
			cnt_q  <= enc.len;
			last_q <= sel_last;
			inv_q  <= enc.invalid;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, cnt_q, byte_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = inv_q;

endmodule

// ----- design/utf8enc_checker.sv -----
// Port-level assertion checker for the UTF-8 code point encoder and its bind.
`include "utf8_code_point_encoder_macros.svh"

module utf8enc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [utf8enc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                               m_axis_tlast,
	input logic                               m_axis_tuser
);
	import utf8enc_pkg::*;

	logic  mid_q;
	len_t  cnt_q;
	byte_t out_byte;
	len_t  out_cnt;
	logic  out_fire;

	assign out_byte = m_axis_tdata[BYTE_W-1:0];
	assign out_cnt  = m_axis_tdata[BYTE_W+LEN_W-1:BYTE_W];
	assign out_fire = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			cnt_q <= '0;
		end else if (out_fire) begin
			mid_q <= !m_axis_tlast;
			cnt_q <= out_cnt;
		end
	end

	`UTF8ENC_ASSERT(a_err_beat, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && out_byte == '0 && !mid_q, "error beat is not a lone zero beat")

	`UTF8ENC_ASSERT(a_cont_beat, m_axis_tvalid && mid_q |-> out_byte[7:6] == 2'b10 && !m_axis_tuser && out_cnt == cnt_q, "mid-sequence beat is not a matching continuation byte")

	`UTF8ENC_ASSERT(a_good_len, m_axis_tvalid && !m_axis_tuser |-> out_cnt != LEN_0 && out_cnt <= LEN_4 && (mid_q || out_byte[7:6] != 2'b10), "accepted sequence has bad length or lead byte")

	`UTF8ENC_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled beat changed")

endmodule

bind utf8_code_point_encoder utf8enc_checker u_utf8enc_checker (.*);
